// ===== rtl/ifp_pkg.sv =====
// Shared types, constants and tables for the IMU feature preprocessor.
// No dependencies; every other RTL and testbench file but ifp_if imports this package.
`timescale 1ns / 1ps
package ifp_pkg;

    // Window length and position counter width.
    localparam int WINDOW_LEN = 128;
    localparam int WIN_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WINDOW_LEN - 1);

    // Configuration register map: paddr[2] selects the register.
    localparam int PADDR_W = 3;
    localparam logic REG_ZP_OFFSET = 1'b0;
    localparam logic REG_INV_SCALE = 1'b1;
    localparam logic signed [7:0] ZP_OFFSET_RST = 8'sd0;
    localparam logic [23:0] INV_SCALE_RST = 24'd65536;

    // Filter coefficients. The second feedback term is stored negated.
    localparam logic signed [25:0] S1_A = 26'sd16156359;
    localparam logic signed [25:0] S1_B0 = 26'sd7093883;
    localparam logic signed [25:0] S1_B1 = 26'sd14187766;
    localparam logic signed [25:0] S1_B2 = 26'sd7093883;
    localparam logic signed [25:0] S2_C1 = 26'sd8227598;
    localparam logic signed [25:0] S2_C2_NEG = -26'sd4039144;
    localparam logic signed [23:0] DEG_Q28 = 24'sd4685083;
    localparam logic signed [71:0] SAT40_HI = 72'sd549755813887;
    localparam logic signed [71:0] SAT40_LO = -72'sd549755813888;

    // Lane sequencer steps.
    localparam logic [4:0] STP_A_LO = 5'd0;
    localparam logic [4:0] STP_A_HI = 5'd1;
    localparam logic [4:0] STP_A_DRAIN = 5'd2;
    localparam logic [4:0] STP_W1 = 5'd3;
    localparam logic [4:0] STP_B0_LO = 5'd4;
    localparam logic [4:0] STP_B0_HI = 5'd5;
    localparam logic [4:0] STP_B1_LO = 5'd6;
    localparam logic [4:0] STP_B1_HI = 5'd7;
    localparam logic [4:0] STP_B2_LO = 5'd8;
    localparam logic [4:0] STP_B2_HI = 5'd9;
    localparam logic [4:0] STP_B_DRAIN = 5'd10;
    localparam logic [4:0] STP_Y1 = 5'd11;
    localparam logic [4:0] STP_C1_LO = 5'd12;
    localparam logic [4:0] STP_C1_HI = 5'd13;
    localparam logic [4:0] STP_C2_LO = 5'd14;
    localparam logic [4:0] STP_C2_HI = 5'd15;
    localparam logic [4:0] STP_C_DRAIN = 5'd16;
    localparam logic [4:0] STP_G = 5'd17;
    localparam logic [4:0] STP_Q_BODY_0 = 5'd18;
    localparam logic [4:0] STP_Q_BODY_1 = 5'd19;
    localparam logic [4:0] STP_Q_BODY_2 = 5'd20;
    localparam logic [4:0] STP_Q_GYRO_0 = 5'd21;
    localparam logic [4:0] STP_Q_GYRO_1 = 5'd22;
    localparam logic [4:0] STP_Q_GYRO_2 = 5'd23;
    localparam logic [4:0] STP_Q_TOTAL_0 = 5'd24;
    localparam logic [4:0] STP_Q_TOTAL_1 = 5'd25;
    localparam logic [4:0] STP_Q_TOTAL_2 = 5'd26;

    // Channel kinds within a lane.
    localparam logic [1:0] KIND_BODY = 2'd0;
    localparam logic [1:0] KIND_GYRO = 2'd1;
    localparam logic [1:0] KIND_TOTAL = 2'd2;

    // Quantizer phases.
    localparam logic [1:0] QPH_NONE = 2'd0;
    localparam logic [1:0] QPH_MUL1 = 2'd1;
    localparam logic [1:0] QPH_MUL2 = 2'd2;
    localparam logic [1:0] QPH_SAT = 2'd3;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_RUN  = 3'b010,
        L_DONE = 3'b100
    } ifp_lane_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ifp_lane_stat_t;

    typedef struct packed {
        logic signed [7:0] body;
        logic signed [7:0] gyro;
        logic signed [7:0] total;
    } ifp_lane_res_t;

    // Saturate to 40 bits signed.
    function automatic logic signed [39:0] ifp_sat40(input logic signed [71:0] v);
        logic signed [39:0] r;
        if (v > SAT40_HI) r = 40'(SAT40_HI);
        else if (v < SAT40_LO) r = 40'(SAT40_LO);
        else r = 40'(v);
        return r;
    endfunction

    // Channel mean in Q24, by kind and axis.
    function automatic logic signed [25:0] ifp_mean(input logic [1:0] kind,
                                                    input logic [1:0] axis);
        logic signed [25:0] m;
        case ({kind, axis})
            {KIND_BODY, 2'd0}:  m = -26'sd10066;
            {KIND_BODY, 2'd1}:  m = 26'sd8389;
            {KIND_BODY, 2'd2}:  m = 26'sd5033;
            {KIND_GYRO, 2'd0}:  m = 26'sd0;
            {KIND_GYRO, 2'd1}:  m = -26'sd10066;
            {KIND_GYRO, 2'd2}:  m = 26'sd48654;
            {KIND_TOTAL, 2'd0}: m = 26'sd12425206;
            {KIND_TOTAL, 2'd1}: m = 26'sd2063598;
            {KIND_TOTAL, 2'd2}: m = 26'sd2719587;
            default:            m = 26'sd0;
        endcase
        return m;
    endfunction

    // Reciprocal of the channel scale in Q16, by kind and axis.
    function automatic logic signed [20:0] ifp_recip(input logic [1:0] kind,
                                                     input logic [1:0] axis);
        logic signed [20:0] r;
        case ({kind, axis})
            {KIND_BODY, 2'd0}:  r = 21'sd584621;
            {KIND_BODY, 2'd1}:  r = 21'sd743882;
            {KIND_BODY, 2'd2}:  r = 21'sd877323;
            {KIND_GYRO, 2'd0}:  r = 21'sd259036;
            {KIND_GYRO, 2'd1}:  r = 21'sd240853;
            {KIND_GYRO, 2'd2}:  r = 21'sd379479;
            {KIND_TOTAL, 2'd0}: r = 21'sd153301;
            {KIND_TOTAL, 2'd1}: r = 21'sd162379;
            {KIND_TOTAL, 2'd2}: r = 21'sd179109;
            default:            r = 21'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ifp_if.sv =====
// Channel interfaces: IMU sample input and quantized feature output.
// Depends on nothing; payload widths follow the channel definitions.
`timescale 1ns / 1ps
interface ifp_sample_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

interface ifp_feature_if;
    logic valid;
    logic ready;
    logic signed [7:0] body_acc_x_q;
    logic signed [7:0] body_acc_y_q;
    logic signed [7:0] body_acc_z_q;
    logic signed [7:0] gyro_x_q;
    logic signed [7:0] gyro_y_q;
    logic signed [7:0] gyro_z_q;
    logic signed [7:0] total_acc_x_q;
    logic signed [7:0] total_acc_y_q;
    logic signed [7:0] total_acc_z_q;
    logic [6:0] sample_index;
    logic window_end;

    modport source (output valid, body_acc_x_q, body_acc_y_q, body_acc_z_q,
                    gyro_x_q, gyro_y_q, gyro_z_q, total_acc_x_q, total_acc_y_q,
                    total_acc_z_q, sample_index, window_end,
                    input ready);
    modport sink (input valid, body_acc_x_q, body_acc_y_q, body_acc_z_q,
                  gyro_x_q, gyro_y_q, gyro_z_q, total_acc_x_q, total_acc_y_q,
                  total_acc_z_q, sample_index, window_end,
                  output ready);
endinterface

// ===== rtl/ifp_lane.sv =====
// One axis lane: two-section gravity filter on a shared multiply-accumulate
// unit, then three quantized channels. Depends on ifp_pkg.
`timescale 1ns / 1ps
module ifp_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              lane_id,
    input  logic                    start,
    input  logic                    take,
    input  logic signed [15:0]      x,
    input  logic signed [15:0]      r,
    input  logic signed [7:0]       zp_offset,
    input  logic [23:0]             inv_input_scale,
    output ifp_pkg::ifp_lane_stat_t stat,
    output ifp_pkg::ifp_lane_res_t  res
);
    import ifp_pkg::*;

    ifp_lane_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;

    // Sample and filter state.
    logic signed [15:0] x_reg;
    logic signed [15:0] r_reg;
    logic signed [39:0] d10_reg, d11_reg, d20_reg, d21_reg;
    logic signed [39:0] w1_reg, y1_reg;
    logic signed [39:0] gyro_reg;
    logic signed [39:0] gyro_prod;
    logic signed [33:0] body_reg;

    // Multiply-accumulate unit.
    logic               iss, hi, clr;
    logic signed [25:0] coef;
    logic signed [39:0] opv;
    logic signed [20:0] opsl;
    logic signed [46:0] prod_next, prod_reg;
    logic               prod_hi_reg, pv_reg;
    logic signed [71:0] addend, acc_next, acc_reg;

    // Quantizer.
    logic [1:0]         qkind, qph;
    logic signed [33:0] qv;
    logic signed [55:0] p1_next, p1_reg;
    logic signed [31:0] nq;
    logic signed [56:0] p2_next, p2_reg;
    logic signed [57:0] tq;
    logic signed [25:0] qq;
    logic signed [7:0]  qsat;
    logic signed [7:0]  qb_reg, qg_reg, qt_reg;

    // Finish computations.
    logic signed [71:0] t1, t2;
    logic signed [39:0] w2;
    logic signed [41:0] gsum, bdiff;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    state_next = L_RUN;
                    step_next = STP_A_LO;
                end
            end
            L_RUN:
            begin
                if (step_reg == STP_Q_TOTAL_2) state_next = L_DONE;
                else step_next = step_reg + 5'd1;
            end
            L_DONE:
            begin
                if (take) state_next = L_IDLE;
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg <= STP_A_LO;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    // Product selection for each filter step.
    always_comb
    begin
        iss = 1'b0;
        hi = 1'b0;
        clr = 1'b0;
        coef = '0;
        opv = '0;
        case (step_reg)
            STP_A_LO:  begin iss = 1'b1; clr = 1'b1; coef = S1_A; opv = d10_reg; end
            STP_A_HI:  begin iss = 1'b1; hi = 1'b1; coef = S1_A; opv = d10_reg; end
            STP_B0_LO: begin iss = 1'b1; clr = 1'b1; coef = S1_B0; opv = w1_reg; end
            STP_B0_HI: begin iss = 1'b1; hi = 1'b1; coef = S1_B0; opv = w1_reg; end
            STP_B1_LO: begin iss = 1'b1; coef = S1_B1; opv = d10_reg; end
            STP_B1_HI: begin iss = 1'b1; hi = 1'b1; coef = S1_B1; opv = d10_reg; end
            STP_B2_LO: begin iss = 1'b1; coef = S1_B2; opv = d11_reg; end
            STP_B2_HI: begin iss = 1'b1; hi = 1'b1; coef = S1_B2; opv = d11_reg; end
            STP_C1_LO: begin iss = 1'b1; clr = 1'b1; coef = S2_C1; opv = d20_reg; end
            STP_C1_HI: begin iss = 1'b1; hi = 1'b1; coef = S2_C1; opv = d20_reg; end
            STP_C2_LO: begin iss = 1'b1; coef = S2_C2_NEG; opv = d21_reg; end
            STP_C2_HI: begin iss = 1'b1; hi = 1'b1; coef = S2_C2_NEG; opv = d21_reg; end
            default: ;
        endcase
        if (state_reg != L_RUN) iss = 1'b0;
    end

    // The 40-bit operand is split into an unsigned low half and a signed high half.
    assign opsl = hi ? {opv[39], opv[39:20]} : {1'b0, opv[19:0]};
    assign prod_next = coef * opsl;
    assign addend = prod_hi_reg ? (72'(prod_reg) <<< 20) : 72'(prod_reg);
    assign acc_next = (clr ? 72'sd0 : acc_reg) + (pv_reg ? addend : 72'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) pv_reg <= 1'b0;
        else pv_reg <= iss;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        prod_hi_reg <= hi;
        acc_reg <= acc_next;
    end

    // Section outputs, gravity and body acceleration.
    assign t1 = (72'(x_reg) <<< 16) + ((acc_reg + (72'sd1 <<< 23)) >>> 24);
    assign t2 = 72'(y1_reg) + ((acc_reg + (72'sd1 <<< 21)) >>> 22);
    assign w2 = ifp_sat40(t2);
    assign gsum = 42'(w2) + 42'(d20_reg);
    assign bdiff = (42'(x_reg) <<< 20) - gsum;

    // Angular rate in Q28 rad/s, formed at full width.
    assign gyro_prod = r_reg * DEG_Q28;

    always_ff @(posedge clk)
    begin
        if (start && state_reg == L_IDLE)
        begin
            x_reg <= x;
            r_reg <= r;
        end
        if (state_reg == L_RUN)
        begin
            if (step_reg == STP_A_LO) gyro_reg <= gyro_prod;
            if (step_reg == STP_W1) w1_reg <= ifp_sat40(t1);
            if (step_reg == STP_Y1) y1_reg <= 40'((acc_reg + (72'sd1 <<< 35)) >>> 36);
            if (step_reg == STP_G) body_reg <= 34'((bdiff + 42'sd128) >>> 8);
        end
    end

    // Filter delay lines, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d10_reg <= '0;
            d11_reg <= '0;
            d20_reg <= '0;
            d21_reg <= '0;
        end
        else if (state_reg == L_RUN && step_reg == STP_G)
        begin
            d11_reg <= d10_reg;
            d10_reg <= w1_reg;
            d21_reg <= d20_reg;
            d20_reg <= w2;
        end
    end

    // Quantizer step decode.
    always_comb
    begin
        qkind = KIND_BODY;
        qph = QPH_NONE;
        case (step_reg)
            STP_Q_BODY_0:  begin qkind = KIND_BODY; qph = QPH_MUL1; end
            STP_Q_BODY_1:  begin qkind = KIND_BODY; qph = QPH_MUL2; end
            STP_Q_BODY_2:  begin qkind = KIND_BODY; qph = QPH_SAT; end
            STP_Q_GYRO_0:  begin qkind = KIND_GYRO; qph = QPH_MUL1; end
            STP_Q_GYRO_1:  begin qkind = KIND_GYRO; qph = QPH_MUL2; end
            STP_Q_GYRO_2:  begin qkind = KIND_GYRO; qph = QPH_SAT; end
            STP_Q_TOTAL_0: begin qkind = KIND_TOTAL; qph = QPH_MUL1; end
            STP_Q_TOTAL_1: begin qkind = KIND_TOTAL; qph = QPH_MUL2; end
            STP_Q_TOTAL_2: begin qkind = KIND_TOTAL; qph = QPH_SAT; end
            default: ;
        endcase
        if (state_reg != L_RUN) qph = QPH_NONE;
    end

    // Channel value in Q24 for the selected kind.
    always_comb
    begin
        case (qkind)
            KIND_BODY: qv = body_reg;
            KIND_GYRO: qv = 34'((gyro_reg + 40'sd128) >>> 8);
            default:   qv = 34'(x_reg) <<< 12;
        endcase
    end

    assign p1_next = (35'(qv) - 35'(ifp_mean(qkind, lane_id))) * ifp_recip(qkind, lane_id);
    assign nq = 32'((p1_reg + (56'sd1 <<< 23)) >>> 24);
    assign p2_next = nq * $signed({1'b0, inv_input_scale});
    assign tq = 58'(p2_reg) + (58'(zp_offset) <<< 32) + (58'sd1 <<< 31);
    assign qq = 26'(tq >>> 32);

    always_comb
    begin
        if (qq > 26'sd127) qsat = 8'sd127;
        else if (qq < -26'sd128) qsat = -8'sd128;
        else qsat = 8'(qq);
    end

    always_ff @(posedge clk)
    begin
        if (qph == QPH_MUL1) p1_reg <= p1_next;
        if (qph == QPH_MUL2) p2_reg <= p2_next;
        if (qph == QPH_SAT)
        begin
            case (qkind)
                KIND_BODY: qb_reg <= qsat;
                KIND_GYRO: qg_reg <= qsat;
                default:   qt_reg <= qsat;
            endcase
        end
    end

    assign stat.idle = (state_reg == L_IDLE);
    assign stat.done = (state_reg == L_DONE);
    assign res.body = qb_reg;
    assign res.gyro = qg_reg;
    assign res.total = qt_reg;

endmodule

// ===== rtl/ifp_merge.sv =====
// Merging stage: gathers the three lanes' channels into one output transaction,
// adds the window position and holds it until taken. Depends on ifp_pkg, ifp_if.
`timescale 1ns / 1ps
module ifp_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ifp_pkg::ifp_lane_stat_t stat [3],
    input  ifp_pkg::ifp_lane_res_t  res [3],
    output logic                   take,
    ifp_feature_if.source          feature_out
);
    import ifp_pkg::*;

    logic                valid_reg;
    logic [WIN_W-1:0]    pos_reg, pos_next;
    ifp_lane_res_t       res_reg [3];
    logic [6:0]          index_reg;
    logic                end_reg;

    // Results move over when every lane is done and the output slot is free.
    assign take = stat[0].done && stat[1].done && stat[2].done
                  && (!valid_reg || feature_out.ready);
    assign pos_next = (pos_reg == WIN_LAST) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                pos_reg <= pos_next;
            end
            else if (feature_out.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
            index_reg <= 7'(pos_reg);
            end_reg <= (pos_reg == WIN_LAST);
        end
    end

    assign feature_out.valid = valid_reg;
    assign feature_out.body_acc_x_q = res_reg[0].body;
    assign feature_out.body_acc_y_q = res_reg[1].body;
    assign feature_out.body_acc_z_q = res_reg[2].body;
    assign feature_out.gyro_x_q = res_reg[0].gyro;
    assign feature_out.gyro_y_q = res_reg[1].gyro;
    assign feature_out.gyro_z_q = res_reg[2].gyro;
    assign feature_out.total_acc_x_q = res_reg[0].total;
    assign feature_out.total_acc_y_q = res_reg[1].total;
    assign feature_out.total_acc_z_q = res_reg[2].total;
    assign feature_out.sample_index = index_reg;
    assign feature_out.window_end = end_reg;

endmodule

// ===== rtl/imu_feature_preprocess_core.sv =====
// Top level of the IMU feature preprocessor: APB registers, three axis lanes
// and the merging stage. Depends on ifp_pkg, ifp_if, ifp_lane, ifp_merge.
//
//   Port         Dir   Kind         Contents
//   sample_in    in    valid/ready  three accelerations and three angular rates
//   feature_out  out   valid/ready  nine int8 channels, sample index, window end
//   APB          in    psel/penable zero-point offset at 0x0, inv_input_scale at 0x4
//
// A sample runs through the lane sequencer, whose length is set by the shared
// multiply-accumulate unit of each lane (two partial products per filter tap),
// then moves into the output register; the lanes take no new sample before that.
// The next sample is accepted while a finished transaction waits at the output.
// Reset clears filter delays, window position and all handshake state.
`timescale 1ns / 1ps
module imu_feature_preprocess_core (
    input  logic                          clk,
    input  logic                          rst_n,
    ifp_sample_if.sink                    sample_in,
    ifp_feature_if.source                 feature_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifp_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ifp_pkg::*;

    logic signed [7:0] zp_reg;
    logic [23:0]       inv_reg;
    ifp_lane_stat_t    stat [3];
    ifp_lane_res_t     res [3];
    logic              take, start;
    logic signed [15:0] xs [3];
    logic signed [15:0] rs [3];

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zp_reg <= ZP_OFFSET_RST;
            inv_reg <= INV_SCALE_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_ZP_OFFSET: zp_reg <= pwdata[7:0];
                REG_INV_SCALE: inv_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ZP_OFFSET: prdata = 32'(zp_reg);
            REG_INV_SCALE: prdata = {8'd0, inv_reg};
            default:       prdata = '0;
        endcase
    end

    // Input transaction starts all lanes together.
    assign sample_in.ready = stat[0].idle && stat[1].idle && stat[2].idle;
    assign start = sample_in.valid && sample_in.ready;

    assign xs[0] = sample_in.accel_x;
    assign xs[1] = sample_in.accel_y;
    assign xs[2] = sample_in.accel_z;
    assign rs[0] = sample_in.rate_x;
    assign rs[1] = sample_in.rate_y;
    assign rs[2] = sample_in.rate_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        ifp_lane u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .lane_id         (2'(a)),
            .start           (start),
            .take            (take),
            .x               (xs[a]),
            .r               (rs[a]),
            .zp_offset       (zp_reg),
            .inv_input_scale (inv_reg),
            .stat            (stat[a]),
            .res             (res[a])
        );
    end

    ifp_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat        (stat),
        .res         (res),
        .take        (take),
        .feature_out (feature_out)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for imu_feature_preprocess_core: it predicts every
// quantized feature transaction and compares it with the block's output.
// Depends on ifp_pkg, ifp_if and the RTL of the core.
`timescale 1ns / 1ps
module tb_top;
    import ifp_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [15:0] acc[3];
        logic signed [15:0] rate[3];
    } imu_sample_t;

    typedef struct {
        logic signed [7:0] body[3];
        logic signed [7:0] gyro[3];
        logic signed [7:0] total[3];
        logic [6:0]        index;
        logic              last;
    } feature_t;

    localparam logic [PADDR_W-1:0] ADDR_ZP_OFFSET = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_INV_SCALE = PADDR_W'(4);
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 64;

    // Fixed filter coefficients and channel normalization, in model order.
    localparam longint BQ1_B0 = 7093883;
    localparam longint BQ1_B1 = 14187766;
    localparam longint BQ1_B2 = 7093883;
    localparam longint BQ1_A  = 16156359;
    localparam longint BQ2_C1 = 8227598;
    localparam longint BQ2_C2 = 4039144;
    localparam longint RAD_Q28 = 4685083;
    localparam longint CH_MEAN[9] = '{-10066, 8389, 5033, 0, -10066, 48654,
                                      12425206, 2063598, 2719587};
    localparam longint CH_RECIP[9] = '{584621, 743882, 877323, 259036, 240853,
                                       379479, 153301, 162379, 179109};

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ifp_sample_if  sample_ch();
    ifp_feature_if feature_ch();

    imu_feature_preprocess_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_in(sample_ch.sink), .feature_out(feature_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: configuration, filter delays and window position.
    longint zp_model;
    longint inv_scale_model;
    wide_t  bq1_w[6];
    wide_t  bq2_w[6];
    int     win_pos;

    imu_sample_t sample_queue[$];
    feature_t    expected_features[$];
    imu_sample_t on_bus;
    int  samples_accepted;
    int  features_seen;
    int  mismatches;
    int  cycles;
    int  send_gap;
    int  recv_stall;
    int  hold_left;
    bit  hold_done;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic wide_t rnd_shift(input wide_t v, input int s);
        return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t clamp40(input wide_t v);
        wide_t hi;
        hi = (wide_t'(1) <<< 39) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic logic signed [7:0] quantize_channel(input wide_t v, input int ch);
        wide_t n;
        wide_t q;
        n = rnd_shift((v - CH_MEAN[ch]) * CH_RECIP[ch], 24);
        q = (n * inv_scale_model + (wide_t'(zp_model) <<< 32) + (wide_t'(1) <<< 31)) >>> 32;
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        return q[7:0];
    endfunction

    // Runs the gravity filters and quantizer for one accepted sample.
    function automatic feature_t compute_features(input imu_sample_t smp);
        feature_t f;
        wide_t x, r, w, y1, g;
        for (int a = 0; a < 3; a++)
        begin
            x = wide_t'(smp.acc[a]);
            r = wide_t'(smp.rate[a]);
            w = clamp40(x * 65536 + rnd_shift(BQ1_A * bq1_w[2*a], 24));
            y1 = rnd_shift(BQ1_B0 * w + BQ1_B1 * bq1_w[2*a] + BQ1_B2 * bq1_w[2*a+1], 36);
            bq1_w[2*a+1] = bq1_w[2*a];
            bq1_w[2*a] = w;
            w = clamp40(y1 + rnd_shift(BQ2_C1 * bq2_w[2*a] - BQ2_C2 * bq2_w[2*a+1], 22));
            g = w + bq2_w[2*a];
            bq2_w[2*a+1] = bq2_w[2*a];
            bq2_w[2*a] = w;
            f.body[a] = quantize_channel(rnd_shift(x * 1048576 - g, 8), a);
            f.gyro[a] = quantize_channel(rnd_shift(r * RAD_Q28, 8), 3 + a);
            f.total[a] = quantize_channel(x * 4096, 6 + a);
        end
        if (win_pos >= WINDOW_LEN)
            win_pos = 0;
        f.index = win_pos[6:0];
        f.last = (win_pos == WINDOW_LEN - 1);
        win_pos = win_pos + 1;
        if (win_pos >= WINDOW_LEN)
            win_pos = 0;
        return f;
    endfunction

    function automatic int pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in feature %0d, %s: expected %0d, got %0d",
                         features_seen, name, want, got);
        end
    endtask

    // Driver: presents queued samples and predicts each accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                expected_features.push_back(compute_features(on_bus));
                samples_accepted++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    sample_ch.valid <= 1'b0;
                end
                else if (sample_queue.size() > 0)
                begin
                    on_bus = sample_queue.pop_front();
                    sample_ch.accel_x <= on_bus.acc[0];
                    sample_ch.accel_y <= on_bus.acc[1];
                    sample_ch.accel_z <= on_bus.acc[2];
                    sample_ch.rate_x <= on_bus.rate[0];
                    sample_ch.rate_y <= on_bus.rate[1];
                    sample_ch.rate_z <= on_bus.rate[2];
                    sample_ch.valid <= 1'b1;
                    // The second hundred of every three hundred samples goes through without gaps.
                    send_gap <= ((samples_accepted / 100) % 3 == 1) ? 0 : pick_delay();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block fills up and stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && samples_accepted >= 300)
        begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end
    end

    // Monitor: random back-pressure and comparison against the oldest prediction.
    always @(posedge clk)
    begin
        feature_t want;
        if (!rst_n)
        begin
            feature_ch.ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (feature_ch.valid && feature_ch.ready)
            begin
                if (expected_features.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected feature transaction %0d", features_seen);
                end
                else
                begin
                    want = expected_features.pop_front();
                    check_field("body_acc_x_q", int'(want.body[0]),
                                int'(feature_ch.body_acc_x_q));
                    check_field("body_acc_y_q", int'(want.body[1]),
                                int'(feature_ch.body_acc_y_q));
                    check_field("body_acc_z_q", int'(want.body[2]),
                                int'(feature_ch.body_acc_z_q));
                    check_field("gyro_x_q", int'(want.gyro[0]), int'(feature_ch.gyro_x_q));
                    check_field("gyro_y_q", int'(want.gyro[1]), int'(feature_ch.gyro_y_q));
                    check_field("gyro_z_q", int'(want.gyro[2]), int'(feature_ch.gyro_z_q));
                    check_field("total_acc_x_q", int'(want.total[0]),
                                int'(feature_ch.total_acc_x_q));
                    check_field("total_acc_y_q", int'(want.total[1]),
                                int'(feature_ch.total_acc_y_q));
                    check_field("total_acc_z_q", int'(want.total[2]),
                                int'(feature_ch.total_acc_z_q));
                    check_field("sample_index", int'(want.index),
                                int'(feature_ch.sample_index));
                    check_field("window_end", int'(want.last), int'(feature_ch.window_end));
                end
                features_seen++;
            end
            if (hold_left > 0)
                feature_ch.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                feature_ch.ready <= 1'b0;
            end
            else if ((features_seen / 150) % 3 == 2)
                feature_ch.ready <= 1'b1;
            else
            begin
                recv_stall <= pick_delay();
                feature_ch.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Register write over APB; the predictor follows at the write edge.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_ZP_OFFSET)
            zp_model = longint'($signed(data[7:0]));
        else if (addr == ADDR_INV_SCALE)
            inv_scale_model = longint'(data[23:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_sample(input int ax, input int ay, input int az,
                                input int rx, input int ry, input int rz);
        imu_sample_t s;
        s.acc[0] = 16'(ax);
        s.acc[1] = 16'(ay);
        s.acc[2] = 16'(az);
        s.rate[0] = 16'(rx);
        s.rate[1] = 16'(ry);
        s.rate[2] = 16'(rz);
        sample_queue.push_back(s);
    endtask

    // Mostly slowly moving motion around 1 g, with some full-range noise.
    task automatic queue_random_samples(input int count);
        int base[3];
        int v[6];
        for (int a = 0; a < 3; a++)
            base[a] = $urandom_range(8192) - 4096;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    base[a] += $urandom_range(400) - 200;
                    if (base[a] > 30000 || base[a] < -30000)
                        base[a] = 0;
                    v[a] = base[a] + $urandom_range(2000) - 1000;
                    v[3+a] = $urandom_range(8000) - 4000;
                end
            end
            else
                for (int k = 0; k < 6; k++)
                    v[k] = int'($signed(16'($urandom())));
            queue_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
        end
    endtask

    task automatic wait_idle();
        while (sample_queue.size() > 0 || sample_ch.valid || expected_features.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.rate_x = '0;
        sample_ch.rate_y = '0;
        sample_ch.rate_z = '0;
        feature_ch.ready = 1'b0;
        zp_model = 0;
        inv_scale_model = 65536;
        for (int i = 0; i < 6; i++)
        begin
            bq1_w[i] = '0;
            bq2_w[i] = '0;
        end
        win_pos = 0;
        samples_accepted = 0;
        features_seen = 0;
        mismatches = 0;
        cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples at reset settings: field extremes and bit patterns.
        queue_sample(0, 0, 0, 0, 0, 0);
        queue_sample(32767, 32767, 32767, 32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_sample(32767, -32768, 32767, -32768, 32767, -32768);
        queue_sample(-32768, 32767, -32768, 32767, -32768, 32767);
        queue_sample(21845, 21845, 21845, 21845, 21845, 21845);
        queue_sample(-21846, -21846, -21846, -21846, -21846, -21846);
        queue_sample(-1, -1, -1, -1, -1, -1);
        queue_sample(1, 1, 1, 1, 1, 1);
        for (int i = 0; i < 8; i++)
            queue_sample(4096, 0, 0, 16, -16, 0);
        for (int i = 0; i < 4; i++)
            queue_sample(0, 0, 4096, 0, 0, 160);
        wait_idle();

        // Extremes of both registers, then the reset values, then random ones.
        apb_write(ADDR_ZP_OFFSET, 32'hFFFF_FF80);
        apb_write(ADDR_INV_SCALE, 32'd0);
        queue_random_samples(150);
        wait_idle();
        apb_write(ADDR_ZP_OFFSET, 32'd127);
        apb_write(ADDR_INV_SCALE, 32'h00FF_FFFF);
        queue_random_samples(150);
        wait_idle();
        apb_write(ADDR_ZP_OFFSET, 32'd0);
        apb_write(ADDR_INV_SCALE, 32'd65536);
        queue_random_samples(500);
        wait_idle();
        for (int p = 0; p < 4; p++)
        begin
            apb_write(ADDR_ZP_OFFSET, $urandom());
            apb_write(ADDR_INV_SCALE, (p % 2) ? $urandom() : $urandom_range(262144, 8192));
            queue_random_samples(155);
            wait_idle();
        end

        if (expected_features.size() != 0)
        begin
            mismatches += expected_features.size();
            $display("%0d predicted features never arrived", expected_features.size());
        end
        $display("Covered %0d samples and %0d feature transactions over seven register",
                 samples_accepted, features_seen);
        $display("settings, with random back-pressure and a long output hold-off.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== imu_feature_preprocess_core.f =====
rtl/ifp_pkg.sv
rtl/ifp_if.sv
rtl/ifp_lane.sv
rtl/ifp_merge.sv
rtl/imu_feature_preprocess_core.sv
verif/tb_top.sv
